@@ hdl/frs_pkg.sv @@
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants of the flame relay supervisor.
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int LIMIT_WIDTH     = 16;
    localparam int CHECK_WIDTH     = 8;

    localparam logic [CHECK_WIDTH-1:0] CHECK_PERIOD = 8'd125;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FLAME_OVERRIDE  = 3'd0,
        REG_SAFE_MODE       = 3'd1,
        REG_MAIN_PULL_IN    = 3'd2,
        REG_MAIN_DROP_OUT   = 3'd3,
        REG_SECOND_PULL_IN  = 3'd4,
        REG_SECOND_DROP_OUT = 3'd5,
        REG_QUALITY_LIMIT   = 3'd6,
        REG_CORE_TEMP_LIMIT = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        SAFE_ERROR  = 3'd0,
        SAFE_SECOND = 3'd1,
        SAFE_QUALITY = 3'd2,
        SAFE_TEMP   = 3'd3,
        SAFE_HOLD   = 3'd4
    } safe_mode_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic target;
        logic clear;
    } relay_ctrl_t;

endpackage

@@ hdl/frs_qualifier.sv @@
// ----------------------------------------------------------------------------
// frs_qualifier
// Pull-in and drop-out qualifier for one flame channel.
// ----------------------------------------------------------------------------
module frs_qualifier
    import frs_pkg::*;
#(
    parameter int DELAY_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   enable,
    input  logic                   seen,
    input  logic [LIMIT_WIDTH-1:0] pull_in,
    input  logic [LIMIT_WIDTH-1:0] drop_delay,
    output logic                   status_next
);

    localparam int CMP_WIDTH = (DELAY_WIDTH > LIMIT_WIDTH) ? DELAY_WIDTH : LIMIT_WIDTH;

    logic                   status_reg;
    logic                   timing_reg;
    logic                   timing_next;
    logic [DELAY_WIDTH-1:0] elapsed_reg;
    logic [DELAY_WIDTH-1:0] elapsed_next;
    logic [LIMIT_WIDTH-1:0] delay;
    logic                   expired;

    assign delay   = status_reg ? drop_delay : pull_in;
    assign expired = CMP_WIDTH'(elapsed_reg) >= CMP_WIDTH'(delay);

    always_comb
    begin
        status_next  = status_reg;
        timing_next  = timing_reg;
        elapsed_next = elapsed_reg;
        priority if (seen == status_reg)
        begin
            timing_next  = 1'b0;
            elapsed_next = '0;
        end
        else if (!timing_reg)
        begin
            timing_next  = 1'b1;
            elapsed_next = '0;
        end
        else if (expired)
        begin
            timing_next  = 1'b0;
            elapsed_next = '0;
            status_next  = seen;
        end
        else
        begin
            if (elapsed_reg != '1)
            begin
                elapsed_next = elapsed_reg + 1'b1;
            end
        end
        if (!enable)
        begin
            status_next  = status_reg;
            timing_next  = timing_reg;
            elapsed_next = elapsed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= 1'b0;
            timing_reg  <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            status_reg  <= status_next;
            timing_reg  <= timing_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

@@ hdl/frs_relay.sv @@
// ----------------------------------------------------------------------------
// frs_relay
// One relay: drive register, feedback check timer, fault flag and switch count.
// ----------------------------------------------------------------------------
module frs_relay
    import frs_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  relay_ctrl_t            ctrl,
    input  logic                   feedback,
    output logic                   drive,
    output logic                   fault,
    output logic [COUNT_WIDTH-1:0] count
);

    logic                   drive_reg;
    logic                   active_reg;
    logic [CHECK_WIDTH-1:0] elapsed_reg;
    logic                   fault_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   changed;

    assign changed = ctrl.accept && ctrl.load && (ctrl.target != drive_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg   <= 1'b0;
            active_reg  <= 1'b0;
            elapsed_reg <= '0;
            fault_reg   <= 1'b0;
            count_reg   <= '0;
        end
        else if (ctrl.accept)
        begin
            if (changed)
            begin
                drive_reg   <= ctrl.target;
                active_reg  <= 1'b1;
                elapsed_reg <= '0;
            end
            else if (active_reg)
            begin
                if (elapsed_reg >= CHECK_PERIOD)
                begin
                    elapsed_reg <= '0;
                    fault_reg   <= feedback ^ drive_reg;
                end
                else
                begin
                    elapsed_reg <= elapsed_reg + 1'b1;
                end
            end
            if (ctrl.clear)
            begin
                count_reg <= '0;
            end
            else if (changed)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign drive = drive_reg;
    assign fault = fault_reg;
    assign count = count_reg;

endmodule

@@ hdl/flame_relay_supervisor_unit.sv @@
// ----------------------------------------------------------------------------
// flame_relay_supervisor_unit
// Flame relay supervisor: flame qualifiers, safe relay source selection and
// relay feedback checking, one tick word in and one status word out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_write            cfg_index, cfg_data
// in        in         in_valid / in_stall  flame, quality, error, temp, pins
// out       out        out_valid / out_stall relays, faults, switch counts
//
// A new word is accepted in every cycle in which in_stall is low.
// The result word is registered and appears the cycle after acceptance.
// Input is stalled only while a result word waits and out_stall is high.
// Reset clears all state and configuration registers to zero.
// ----------------------------------------------------------------------------
module flame_relay_supervisor_unit
    import frs_pkg::*;
#(
    parameter int DELAY_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       main_flame_seen,
    input  logic                       second_flame_seen,
    input  logic [15:0]                quality_value,
    input  logic                       any_error,
    input  logic [15:0]                core_temp,
    input  logic                       flame_feedback,
    input  logic                       safe_feedback,
    input  logic                       clear_counts,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       flame_relay_on,
    output logic                       safe_relay_on,
    output logic                       flame_relay_fault,
    output logic                       safe_relay_fault,
    output logic [COUNT_WIDTH-1:0]     flame_switch_count,
    output logic [COUNT_WIDTH-1:0]     safe_switch_count
);

    logic                   flame_override_reg;
    logic [2:0]             safe_mode_reg;
    logic [LIMIT_WIDTH-1:0] main_pull_in_reg;
    logic [LIMIT_WIDTH-1:0] main_drop_delay_reg;
    logic [LIMIT_WIDTH-1:0] second_pull_in_reg;
    logic [LIMIT_WIDTH-1:0] second_drop_delay_reg;
    logic [LIMIT_WIDTH-1:0] quality_limit_reg;
    logic [LIMIT_WIDTH-1:0] core_temp_limit_reg;
    logic                   out_valid_reg;

    logic                   accept;
    logic                   main_status;
    logic                   second_status;
    logic                   second_enable;
    relay_ctrl_t            flame_ctrl;
    relay_ctrl_t            safe_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flame_override_reg    <= 1'b0;
            safe_mode_reg         <= 3'd0;
            main_pull_in_reg      <= '0;
            main_drop_delay_reg   <= '0;
            second_pull_in_reg    <= '0;
            second_drop_delay_reg <= '0;
            quality_limit_reg     <= '0;
            core_temp_limit_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FLAME_OVERRIDE:  flame_override_reg    <= cfg_data[0];
                REG_SAFE_MODE:       safe_mode_reg         <= cfg_data[2:0];
                REG_MAIN_PULL_IN:    main_pull_in_reg      <= cfg_data;
                REG_MAIN_DROP_OUT:   main_drop_delay_reg   <= cfg_data;
                REG_SECOND_PULL_IN:  second_pull_in_reg    <= cfg_data;
                REG_SECOND_DROP_OUT: second_drop_delay_reg <= cfg_data;
                REG_QUALITY_LIMIT:   quality_limit_reg     <= cfg_data;
                REG_CORE_TEMP_LIMIT: core_temp_limit_reg   <= cfg_data;
                default:             flame_override_reg    <= flame_override_reg;
            endcase
        end
    end

    assign in_stall      = out_valid_reg && out_stall;
    assign accept        = in_valid && !in_stall;
    assign second_enable = accept && (safe_mode_reg == SAFE_SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    frs_qualifier #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_main_qual (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (accept),
        .seen        (main_flame_seen),
        .pull_in     (main_pull_in_reg),
        .drop_delay  (main_drop_delay_reg),
        .status_next (main_status)
    );

    frs_qualifier #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_second_qual (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (second_enable),
        .seen        (second_flame_seen),
        .pull_in     (second_pull_in_reg),
        .drop_delay  (second_drop_delay_reg),
        .status_next (second_status)
    );

    always_comb
    begin
        flame_ctrl.accept = accept;
        flame_ctrl.load   = 1'b1;
        flame_ctrl.target = flame_override_reg || main_status;
        flame_ctrl.clear  = clear_counts;

        safe_ctrl.accept  = accept;
        safe_ctrl.load    = 1'b1;
        safe_ctrl.clear   = clear_counts;
        unique case (safe_mode_reg)
            SAFE_ERROR:   safe_ctrl.target = any_error;
            SAFE_SECOND:  safe_ctrl.target = flame_override_reg || second_status;
            SAFE_QUALITY: safe_ctrl.target = quality_value >= quality_limit_reg;
            SAFE_TEMP:    safe_ctrl.target = core_temp > core_temp_limit_reg;
            default:
            begin
                safe_ctrl.load   = 1'b0;
                safe_ctrl.target = 1'b0;
            end
        endcase
    end

    frs_relay #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_flame_relay (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (flame_ctrl),
        .feedback (flame_feedback),
        .drive    (flame_relay_on),
        .fault    (flame_relay_fault),
        .count    (flame_switch_count)
    );

    frs_relay #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_safe_relay (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (safe_ctrl),
        .feedback (safe_feedback),
        .drive    (safe_relay_on),
        .fault    (safe_relay_fault),
        .count    (safe_switch_count)
    );

    assign out_valid = out_valid_reg;

    // Every accepted word leaves a result word behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result");

    // A clear request empties both switch counters in the same tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && clear_counts |=> (flame_switch_count == '0) && (safe_switch_count == '0))
        else $error("switch counters not cleared");

    // With the override set, the flame relay is driven after every tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && flame_override_reg |=> flame_relay_on)
        else $error("flame override not applied");

    // In hold mode the safe relay drive never changes.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (safe_mode_reg == SAFE_HOLD) |=> $stable(safe_relay_on))
        else $error("safe relay moved in hold mode");

endmodule
